// ===== hdl/bus_enumeration_packet_handler_top_assert.svh =====
// assertion macros used by the bus enumeration handler top file
`ifndef BUS_ENUMERATION_PACKET_HANDLER_TOP_ASSERT_SVH
`define BUS_ENUMERATION_PACKET_HANDLER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bus enumeration check failed");

// next-cycle implication, checked outside reset
`define BE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bus enumeration check failed");

`endif

// ===== hdl/bus_enum_pkg.sv =====
`timescale 1ns / 1ps

package bus_enum_pkg;

   // default number of id bytes (and of mask bytes)
   localparam int ID_BYTES_DEF = 8;

   // magic key length and byte counter ceiling
   localparam int         KEY_LEN   = 21;
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // packet type codes
   typedef enum logic [7:0] {
      PKT_ENTER    = 8'hF0,
      PKT_EXIT     = 8'hF1,
      PKT_SELECT   = 8'hF2,
      PKT_RESET    = 8'hF3,
      PKT_UNSELECT = 8'hF4
   } pkt_code_type;

   // bus action codes
   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_HOLD    = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   // per-packet tracker view, including the byte of the current item
   typedef struct packed {
      logic [7:0] count;
      logic       key_ok;
      logic       id_ok;
   } trk_type;

   // magic key byte at a given position
   function automatic logic [7:0] key_byte(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'hE6;
         5'd1:    b = 8'hAD;
         5'd2:    b = 8'hBB;
         5'd3:    b = 8'hE3;
         5'd4:    b = 8'h82;
         5'd5:    b = 8'h93;
         5'd6:    b = 8'hE3;
         5'd7:    b = 8'h81;
         5'd8:    b = 8'hA0;
         5'd9:    b = 8'hE4;
         5'd10:   b = 8'hB8;
         5'd11:   b = 8'h96;
         5'd12:   b = 8'hE7;
         5'd13:   b = 8'h95;
         5'd14:   b = 8'h8C;
         5'd15:   b = 8'hE6;
         5'd16:   b = 8'h88;
         5'd17:   b = 8'hA6;
         5'd18:   b = 8'hE7;
         5'd19:   b = 8'hB7;
         5'd20:   b = 8'h9A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/bus_enum_track.sv =====
`timescale 1ns / 1ps

module bus_enum_track #(
   parameter int IdBytes = bus_enum_pkg::ID_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic                  clear,
   input  logic [7:0]            data,
   input  logic [8*IdBytes-1:0]  device_id,
   output bus_enum_pkg::trk_type trk
);

   localparam int IdxW = (IdBytes > 1) ? $clog2(IdBytes) : 1;

   logic [7:0]      count_ff;
   logic [7:0]      count_in;
   logic            key_ok_ff;
   logic            key_ok_in;
   logic            id_ok_ff;
   logic            id_ok_in;
   logic [7:0]      id_store_ff [IdBytes];
   logic [7:0]      rel;
   logic [IdxW-1:0] wr_idx;
   logic [IdxW-1:0] rd_idx;
   logic [8*IdBytes-1:0] dev_shift;
   logic [7:0]      dev_byte;
   logic            in_id;
   logic            in_mask;

   // position decode for the current byte
   assign rel       = count_ff - 8'(IdBytes);
   assign wr_idx    = count_ff[IdxW-1:0];
   assign rd_idx    = rel[IdxW-1:0];
   assign in_id     = (count_ff < 8'(IdBytes));
   assign in_mask   = !in_id && (count_ff < 8'(2 * IdBytes));
   assign dev_shift = device_id >> {rd_idx, 3'b000};
   assign dev_byte  = dev_shift[7:0];

   // tracker values including this item's byte
   always_comb begin
      count_in  = count_ff;
      key_ok_in = key_ok_ff;
      id_ok_in  = id_ok_ff;
      if (take) begin
         if (count_ff < 8'(bus_enum_pkg::KEY_LEN) &&
             data != bus_enum_pkg::key_byte(count_ff[4:0])) begin
            key_ok_in = 1'b0;
         end
         if (in_mask && (((id_store_ff[rd_idx] ^ dev_byte) & data) != 8'h00)) begin
            id_ok_in = 1'b0;
         end
         if (count_ff != bus_enum_pkg::COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
      end
   end

   assign trk.count  = count_in;
   assign trk.key_ok = key_ok_in;
   assign trk.id_ok  = id_ok_in;

   // per-packet trackers, cleared at packet end
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         count_ff  <= 8'd0;
         key_ok_ff <= 1'b1;
         id_ok_ff  <= 1'b1;
      end else begin
         count_ff  <= count_in;
         key_ok_ff <= key_ok_in;
         id_ok_ff  <= id_ok_in;
      end
   end

   // id byte store
   always_ff @(posedge clock) begin
      if (take && in_id) begin
         id_store_ff[wr_idx] <= data;
      end
   end

endmodule

// ===== hdl/bus_enum_decide.sv =====
`timescale 1ns / 1ps

module bus_enum_decide #(
   parameter int IdBytes = bus_enum_pkg::ID_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            packet_type,
   input  bus_enum_pkg::trk_type trk,
   output logic [1:0]            action,
   output logic                  enumerating_now,
   output logic                  bus_held_now
);

   logic enumerating_ff;
   logic enumerating_in;
   logic bus_held_ff;
   logic bus_held_in;
   logic id_hit;
   logic key_hit;

   assign id_hit  = trk.id_ok && (trk.count >= 8'(2 * IdBytes));
   assign key_hit = trk.key_ok && (trk.count == 8'(bus_enum_pkg::KEY_LEN));

   // packet-end decision
   always_comb begin
      enumerating_in = enumerating_ff;
      bus_held_in    = bus_held_ff;
      action         = bus_enum_pkg::ACT_NONE;
      case (packet_type)
         bus_enum_pkg::PKT_ENTER: begin
            if (key_hit) begin
               enumerating_in = 1'b1;
               bus_held_in    = 1'b1;
               action         = bus_enum_pkg::ACT_HOLD;
            end
         end
         bus_enum_pkg::PKT_EXIT: begin
            if (enumerating_ff) begin
               enumerating_in = 1'b0;
               bus_held_in    = 1'b0;
               action         = bus_enum_pkg::ACT_RELEASE;
            end
         end
         bus_enum_pkg::PKT_SELECT: begin
            if (enumerating_ff && id_hit) begin
               bus_held_in = 1'b0;
               action      = bus_enum_pkg::ACT_RELEASE;
            end
         end
         bus_enum_pkg::PKT_RESET: begin
            if (enumerating_ff) begin
               bus_held_in = 1'b1;
               action      = bus_enum_pkg::ACT_HOLD;
            end
         end
         bus_enum_pkg::PKT_UNSELECT: begin
            if (enumerating_ff && id_hit) begin
               bus_held_in = 1'b1;
               action      = bus_enum_pkg::ACT_HOLD;
            end
         end
         default: begin
            action = bus_enum_pkg::ACT_NONE;
         end
      endcase
   end

   assign enumerating_now = enumerating_in;
   assign bus_held_now    = bus_held_in;

   // mode and bus state
   always_ff @(posedge clock) begin
      if (reset) begin
         enumerating_ff <= 1'b0;
         bus_held_ff    <= 1'b0;
      end else if (fire) begin
         enumerating_ff <= enumerating_in;
         bus_held_ff    <= bus_held_in;
      end
   end

endmodule

// ===== hdl/bus_enumeration_packet_handler_top.sv =====
`timescale 1ns / 1ps

// Sensor-bus enumeration packet handler. Payload bytes come in one item per
// cycle on the req_ channel; an item with req_last_of_packet high closes the
// packet and yields one rsp_ item with the bus action and the mode flags, all
// other items yield none. An item is taken into an input register, evaluated
// against the per-packet trackers combinationally and its result lands in
// an output register, so a new item is accepted every cycle unless the input
// stalls. The input stalls only while a packet-end item waits behind a result
// that the rsp_ side has not taken. csr_device_id is written through the
// csr_ channel, always ready, and must be written only while the block is idle.

`include "bus_enumeration_packet_handler_top_assert.svh"

module bus_enumeration_packet_handler_top #(
   parameter int IdBytes = bus_enum_pkg::ID_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // item input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_packet_type,
   input  logic [7:0]           req_payload_byte,
   input  logic                 req_has_byte,
   input  logic                 req_last_of_packet,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_bus_action,
   output logic                 rsp_enumerating_now,
   output logic                 rsp_bus_held_now,
   // device id register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [63:0]          csr_device_id
);

   logic        in_valid_ff;
   logic [7:0]  in_type_ff;
   logic [7:0]  in_byte_ff;
   logic        in_has_ff;
   logic        in_last_ff;
   logic        advance;
   logic        load;
   logic [63:0] device_id_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_action_ff;
   logic        rsp_enum_ff;
   logic        rsp_held_ff;
   logic [1:0]  action;
   logic        enum_now;
   logic        held_now;
   bus_enum_pkg::trk_type trk;

   // handshake control
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign load      = !in_valid_ff || advance;
   assign req_stall = !load;
   assign csr_ready = 1'b1;

   // device id register
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         device_id_ff <= csr_device_id;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         in_type_ff <= req_packet_type;
         in_byte_ff <= req_payload_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last_of_packet;
      end
   end

   bus_enum_track #(
      .IdBytes(IdBytes)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .take      (advance && in_has_ff),
      .clear     (advance && in_last_ff),
      .data      (in_byte_ff),
      .device_id (device_id_ff[8*IdBytes-1:0]),
      .trk       (trk)
   );

   bus_enum_decide #(
      .IdBytes(IdBytes)
   ) u_decide (
      .clock           (clock),
      .reset           (reset),
      .fire            (advance && in_last_ff),
      .packet_type     (in_type_ff),
      .trk             (trk),
      .action          (action),
      .enumerating_now (enum_now),
      .bus_held_now    (held_now)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_action_ff <= action;
         rsp_enum_ff   <= enum_now;
         rsp_held_ff   <= held_now;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bus_action      = rsp_action_ff;
   assign rsp_enumerating_now = rsp_enum_ff;
   assign rsp_bus_held_now    = rsp_held_ff;

   // checks
   `BE_ASSERT_IMPL(a_stall_only_busy, clock, reset, req_stall, in_valid_ff && in_last_ff)
   `BE_ASSERT_IMPL(a_hold_is_held, clock, reset,
      rsp_valid_ff && rsp_action_ff == bus_enum_pkg::ACT_HOLD, rsp_held_ff && rsp_enum_ff)
   `BE_ASSERT_IMPL(a_release_not_held, clock, reset,
      rsp_valid_ff && rsp_action_ff == bus_enum_pkg::ACT_RELEASE, !rsp_held_ff)
   `BE_ASSERT_IMPL(a_held_needs_enum, clock, reset, rsp_valid_ff && rsp_held_ff, rsp_enum_ff)
   `BE_ASSERT_NEXT(a_result_kept, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)

endmodule

// ===== tb/bus_enumeration_packet_handler_top_test.sv =====
`timescale 1ns / 1ps

module bus_enumeration_packet_handler_top_test;

   localparam int ID_BYTES = bus_enum_pkg::ID_BYTES_DEF;

   // enumeration key, byte 0 in the low bits
   localparam logic [bus_enum_pkg::KEY_LEN*8-1:0] ENUM_KEY = {
      8'h9A, 8'hB7, 8'hE7, 8'hA6, 8'h88, 8'hE6, 8'h8C, 8'h95, 8'hE7, 8'h96, 8'hB8,
      8'hE4, 8'hA0, 8'h81, 8'hE3, 8'h93, 8'h82, 8'hE3, 8'hBB, 8'hAD, 8'hE6
   };

   typedef struct {
      bus_enum_pkg::action_type action;
      logic                     enum_now;
      logic                     held_now;
   } bus_verdict_type;

   // block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_packet_type = 8'h00;
   logic [7:0]  req_payload_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last_of_packet = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_bus_action;
   logic        rsp_enumerating_now;
   logic        rsp_bus_held_now;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_device_id = 64'd0;

   // predicted handler state
   logic        pred_enum;
   logic        pred_held;
   logic [7:0]  pred_count;
   logic        pred_key_ok;
   logic        pred_id_ok;
   logic [7:0]  pred_id_store [0:7];
   logic [63:0] pred_dev_id;

   bus_verdict_type verdict_q [$];
   logic [7:0]      pkt_buf [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   bit              send_gaps = 1'b0;
   bit              rsp_gaps = 1'b0;
   int              hold_request = 0;
   int              hold_left = 0;
   int              stall_left = 0;

   bus_enumeration_packet_handler_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_packet_type     (req_packet_type),
      .req_payload_byte    (req_payload_byte),
      .req_has_byte        (req_has_byte),
      .req_last_of_packet  (req_last_of_packet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_bus_action      (rsp_bus_action),
      .rsp_enumerating_now (rsp_enumerating_now),
      .rsp_bus_held_now    (rsp_bus_held_now),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_device_id       (csr_device_id)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // tracker update for one payload byte
   function automatic void track_byte(input logic [7:0] b);
      int idx;
      int k;
      idx = pred_count;
      if (idx < bus_enum_pkg::KEY_LEN && b != ENUM_KEY[idx*8 +: 8])
         pred_key_ok = 1'b0;
      if (idx < ID_BYTES) begin
         pred_id_store[idx & 7] = b;
      end else if (idx < 2 * ID_BYTES) begin
         k = (idx - ID_BYTES) & 7;
         if (((pred_id_store[k] ^ pred_dev_id[k*8 +: 8]) & b) != 8'h00)
            pred_id_ok = 1'b0;
      end
      if (pred_count != bus_enum_pkg::COUNT_MAX)
         pred_count = pred_count + 8'd1;
   endfunction

   // bus decision for one item; returns 1 when the item closes a packet
   function automatic bit compute_bus_verdict(input logic [7:0] ptype, input logic [7:0] b,
                                              input logic has, input logic last,
                                              output bus_verdict_type v);
      bit id_ok;
      bus_enum_pkg::action_type act;
      if (has)
         track_byte(b);
      if (!last)
         return 1'b0;
      id_ok = pred_id_ok && (pred_count >= 2 * ID_BYTES);
      act = bus_enum_pkg::ACT_NONE;
      case (ptype)
         bus_enum_pkg::PKT_ENTER: begin
            if (pred_count == bus_enum_pkg::KEY_LEN && pred_key_ok) begin
               pred_enum = 1'b1;
               pred_held = 1'b1;
               act = bus_enum_pkg::ACT_HOLD;
            end
         end
         bus_enum_pkg::PKT_EXIT: begin
            if (pred_enum) begin
               pred_enum = 1'b0;
               pred_held = 1'b0;
               act = bus_enum_pkg::ACT_RELEASE;
            end
         end
         bus_enum_pkg::PKT_SELECT: begin
            if (pred_enum && id_ok) begin
               pred_held = 1'b0;
               act = bus_enum_pkg::ACT_RELEASE;
            end
         end
         bus_enum_pkg::PKT_RESET: begin
            if (pred_enum) begin
               pred_held = 1'b1;
               act = bus_enum_pkg::ACT_HOLD;
            end
         end
         bus_enum_pkg::PKT_UNSELECT: begin
            if (pred_enum && id_ok) begin
               pred_held = 1'b1;
               act = bus_enum_pkg::ACT_HOLD;
            end
         end
         default: ;
      endcase
      pred_count = 8'd0;
      pred_key_ok = 1'b1;
      pred_id_ok = 1'b1;
      v.action = act;
      v.enum_now = pred_enum;
      v.held_now = pred_held;
      return 1'b1;
   endfunction

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      bus_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result action=%0d enum=%0b held=%0b", $realtime,
                        rsp_bus_action, rsp_enumerating_now, rsp_bus_held_now);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_bus_action !== want.action || rsp_enumerating_now !== want.enum_now ||
                rsp_bus_held_now !== want.held_now) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: exp action %0d enum %0b held %0b, got %0d %0b %0b",
                           $realtime, want.action, want.enum_now, want.held_now,
                           rsp_bus_action, rsp_enumerating_now, rsp_bus_held_now);
            end
         end
      end
   end

   // result side stall: long hold on request, else random gaps
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_gaps)
            stall_left = rand_gap();
      end
   end

   // offer one item and wait until it is taken
   task automatic send_item(input logic [7:0] ptype, input logic [7:0] b,
                            input logic has, input logic last);
      int gap;
      bus_verdict_type v;
      gap = send_gaps ? rand_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_packet_type <= ptype;
      req_payload_byte <= b;
      req_has_byte <= has;
      req_last_of_packet <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (compute_bus_verdict(ptype, b, has, last, v))
         verdict_q.push_back(v);
      if (has || last)
         items_sent++;
   endtask

   // send the bytes in pkt_buf as one packet of the given type
   task automatic send_packet(input logic [7:0] ptype, input bit empty_end);
      int n;
      logic [7:0] t;
      n = pkt_buf.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom), 8'($urandom), 1'b0, 1'b0);
         t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ptype;
         if (i == n - 1 && !empty_end)
            send_item(ptype, pkt_buf[i], 1'b1, 1'b1);
         else
            send_item(t, pkt_buf[i], 1'b1, 1'b0);
      end
      if (n == 0 || empty_end)
         send_item(ptype, 8'($urandom), 1'b0, 1'b1);
      pkt_buf.delete();
   endtask

   // key bytes, optionally cut, lengthened or with one bit flipped
   task automatic load_key(input int len, input bit corrupt);
      int pos;
      for (int i = 0; i < len; i++)
         pkt_buf.push_back(i < bus_enum_pkg::KEY_LEN ? ENUM_KEY[i*8 +: 8] : 8'($urandom));
      if (corrupt && len > 0) begin
         pos = $urandom_range(0, (len < bus_enum_pkg::KEY_LEN ? len : bus_enum_pkg::KEY_LEN) - 1);
         pkt_buf[pos] = pkt_buf[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
   endtask

   // id bytes then mask bytes, matching the device id or not
   task automatic load_id(input bit match, input int len);
      logic [7:0] ids [0:7];
      logic [7:0] masks [0:7];
      logic [7:0] diff;
      int bad;
      bad = $urandom_range(0, ID_BYTES - 1);
      for (int k = 0; k < ID_BYTES; k++) begin
         ids[k] = ($urandom_range(0, 2) == 0) ? pred_dev_id[k*8 +: 8] : 8'($urandom);
         if (!match && k == bad && ids[k] == pred_dev_id[k*8 +: 8])
            ids[k] = ids[k] ^ (8'd1 << $urandom_range(0, 7));
         diff = ids[k] ^ pred_dev_id[k*8 +: 8];
         masks[k] = 8'($urandom) & ~diff;
         if (!match && k == bad)
            masks[k] = masks[k] | (diff & -diff);
      end
      for (int i = 0; i < len; i++) begin
         if (i < ID_BYTES)
            pkt_buf.push_back(ids[i]);
         else if (i < 2 * ID_BYTES)
            pkt_buf.push_back(masks[i - ID_BYTES]);
         else
            pkt_buf.push_back(8'($urandom));
      end
   endtask

   task automatic load_noise(input int len);
      for (int i = 0; i < len; i++)
         pkt_buf.push_back(8'($urandom));
   endtask

   // let every outstanding result arrive and the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_device_id(input logic [63:0] id);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_device_id <= id;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pred_dev_id = id;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // commands that must do nothing outside enumeration
   task automatic test_idle_commands();
      send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
      send_packet(bus_enum_pkg::PKT_RESET, 1'b0);
      load_id(1'b1, 2 * ID_BYTES);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      send_packet(bus_enum_pkg::PKT_UNSELECT, 1'b0);
      send_packet(8'h00, 1'b0);
      send_packet(8'hFF, 1'b0);
   endtask

   // enter with good and bad keys, then exit
   task automatic test_enter_exit();
      load_key(bus_enum_pkg::KEY_LEN - 1, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      load_key(bus_enum_pkg::KEY_LEN, 1'b1);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      load_key(bus_enum_pkg::KEY_LEN, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      load_key(bus_enum_pkg::KEY_LEN, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b1);
      load_key(bus_enum_pkg::KEY_LEN + 1, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
      send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
   endtask

   // masked id match for select and unselect at one device id
   task automatic test_id_match(input logic [63:0] id);
      write_device_id(id);
      load_key(bus_enum_pkg::KEY_LEN, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      load_id(1'b1, 2 * ID_BYTES);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      load_id(1'b1, 2 * ID_BYTES);
      send_packet(bus_enum_pkg::PKT_UNSELECT, 1'b1);
      load_id(1'b0, 2 * ID_BYTES);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      load_id(1'b1, 2 * ID_BYTES - 1);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      send_packet(bus_enum_pkg::PKT_RESET, 1'b0);
      load_id(1'b1, 2 * ID_BYTES + 3);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      load_id(1'b0, 2 * ID_BYTES);
      send_packet(bus_enum_pkg::PKT_UNSELECT, 1'b0);
      send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
   endtask

   // byte count saturation on long packets
   task automatic test_long_packets();
      load_key(bus_enum_pkg::KEY_LEN, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      load_id(1'b1, 300);
      send_packet(bus_enum_pkg::PKT_SELECT, 1'b0);
      load_id(1'b1, 256);
      send_packet(bus_enum_pkg::PKT_UNSELECT, 1'b0);
      load_key(bus_enum_pkg::KEY_LEN + 255, 1'b0);
      send_packet(bus_enum_pkg::PKT_ENTER, 1'b0);
      send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
   endtask

   // result side held off while short packets keep coming
   task automatic test_backpressure();
      hold_request = 150;
      for (int i = 0; i < 60; i++) begin
         if (i % 3 == 0)
            load_noise($urandom_range(0, 2));
         send_packet(8'($urandom_range(8'hF0, 8'hF5)), 1'b0);
      end
   endtask

   // mostly well-formed command sequences with random content
   task automatic test_random_traffic(input int target);
      int r;
      int next_cfg;
      logic [7:0] t;
      next_cfg = items_sent + 350;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) send_gaps = ~send_gaps;
         if ($urandom_range(0, 9) == 0) rsp_gaps = ~rsp_gaps;
         if (items_sent >= next_cfg) begin
            r = $urandom_range(0, 3);
            write_device_id(r == 0 ? 64'd0 : r == 1 ? ~64'd0 : {$urandom, $urandom});
            next_cfg = items_sent + 350;
         end
         r = $urandom_range(0, 99);
         if (r < 15) begin
            load_key(bus_enum_pkg::KEY_LEN, 1'b0);
            send_packet(bus_enum_pkg::PKT_ENTER, $urandom_range(0, 3) == 0);
         end else if (r < 22) begin
            load_key($urandom_range(0, 1) ? bus_enum_pkg::KEY_LEN : $urandom_range(0, 25),
                     $urandom_range(0, 1));
            send_packet(bus_enum_pkg::PKT_ENTER, $urandom_range(0, 3) == 0);
         end else if (r < 50) begin
            load_id($urandom_range(0, 9) < 7, $urandom_range(0, 5) == 0 ?
                    $urandom_range(0, 24) : 2 * ID_BYTES);
            send_packet($urandom_range(0, 1) ? bus_enum_pkg::PKT_SELECT :
                                               bus_enum_pkg::PKT_UNSELECT,
                        $urandom_range(0, 3) == 0);
         end else if (r < 51) begin
            load_id(1'b1, $urandom_range(250, 300));
            send_packet($urandom_range(0, 1) ? bus_enum_pkg::PKT_SELECT :
                                               bus_enum_pkg::PKT_UNSELECT, 1'b0);
         end else if (r < 63) begin
            load_noise($urandom_range(0, 3));
            send_packet(bus_enum_pkg::PKT_RESET, $urandom_range(0, 3) == 0);
         end else if (r < 73) begin
            load_noise($urandom_range(0, 3));
            send_packet(bus_enum_pkg::PKT_EXIT, 1'b0);
         end else begin
            load_noise($urandom_range(0, 30));
            t = 8'($urandom);
            if ($urandom_range(0, 1)) t = 8'($urandom_range(8'hF0, 8'hF4));
            send_packet(t, $urandom_range(0, 3) == 0);
         end
      end
   endtask

   initial begin
      $timeformat(-9, 0, " ns", 0);
      pred_enum = 1'b0;
      pred_held = 1'b0;
      pred_count = 8'd0;
      pred_key_ok = 1'b1;
      pred_id_ok = 1'b1;
      pred_dev_id = 64'd0;
      for (int k = 0; k < 8; k++) pred_id_store[k] = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_commands();
      test_enter_exit();
      test_id_match(~64'd0);
      test_id_match(64'd0);
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      test_id_match({$urandom, $urandom});
      test_long_packets();
      send_gaps = 1'b0;
      test_backpressure();
      // fill up to about 1700 items in total
      test_random_traffic(1700);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && verdict_q.size() == 0)
         $display("** bus_enumeration_packet_handler_top: PASSED **");
      else
         $display("** bus_enumeration_packet_handler_top: FAILED **");
      $finish;
   end

   // run time limit
   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", verdict_q.size());
      $display("** bus_enumeration_packet_handler_top: FAILED **");
      $finish;
   end

endmodule

// ===== bus_enumeration_packet_handler_top.f =====
+incdir+hdl
hdl/bus_enum_pkg.sv
hdl/bus_enum_track.sv
hdl/bus_enum_decide.sv
hdl/bus_enumeration_packet_handler_top.sv
tb/bus_enumeration_packet_handler_top_test.sv
